// ===== hdl/mie_pkg.sv =====
// package for the extended euclidean modular inverse: sequencer states and field width
`default_nettype none

package mie_pkg;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIVIDE,
      ST_UPDATE,
      ST_FIX
   } state_type;

   localparam int unsigned FIELD_BITS = 63;

endpackage

`default_nettype wire

// ===== hdl/modular_inverse_ext_euclid.sv =====
// modular inverse by the extended euclidean algorithm, one shared iterative step unit
//
// Usage: drive req_value and req_modulus and raise start while busy is low; the
// transaction is taken at that clock edge and busy rises on the next cycle.
// The block then runs one euclid step after another on a single shared unit:
// a restoring divider that produces one quotient bit per cycle, with an
// accumulator that builds quotient times coefficient from the same bits, and
// the same accumulator adder then forms the new coefficient and the final
// sign fix. Each euclid step is a zero check, one divide step per quotient
// bit and an update; a zero remainder at the check leads to the sign fix.
// The result is shown on rsp_inverse for exactly one cycle with rsp_valid high.
// The receiver cannot stall; the result register is separate from the
// sequencer, so a new transaction may be started in the cycle the strobe shows.
// Reset (synchronous, active high) returns the sequencer to idle and clears
// the strobe; an item in progress is dropped.
`default_nettype none

module modular_inverse_ext_euclid
   import mie_pkg::*;
#(
   parameter int unsigned WORD_BITS = 64
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire logic [FIELD_BITS-1:0] req_value,
   input  wire logic [FIELD_BITS-1:0] req_modulus,
   output logic                       rsp_valid,
   output logic [FIELD_BITS-1:0]      rsp_inverse
);

   localparam int unsigned CNT_BITS = $clog2(WORD_BITS);
   localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(WORD_BITS - 1);

   state_type state_ff, state_in;

   logic [WORD_BITS-1:0] rem_old_ff, rem_old_in;
   logic [WORD_BITS-1:0] rem_new_ff, rem_new_in;
   logic [WORD_BITS-1:0] co_old_ff, co_old_in;
   logic [WORD_BITS-1:0] co_new_ff, co_new_in;
   logic [WORD_BITS-1:0] mod_ff, mod_in;
   logic [WORD_BITS-1:0] prod_ff, prod_in;
   logic [WORD_BITS-1:0] part_ff, part_in;
   logic [WORD_BITS-1:0] quo_ff, quo_in;
   logic [CNT_BITS-1:0]  cnt_ff, cnt_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [FIELD_BITS-1:0] rsp_inverse_ff, rsp_inverse_in;

   logic [63:0]          value_ext, modulus_ext, fix_ext;
   logic [WORD_BITS-1:0] value_w, modulus_w;

   // divider step
   logic [WORD_BITS:0]   trial_shift, trial_diff;
   logic                 quo_bit;
   logic [WORD_BITS-1:0] part_next;

   // shared accumulator adder
   logic [WORD_BITS-1:0] acc_a, acc_b, acc_sum;
   logic                 acc_cin;

   logic accept, div_last, rem_zero;

   assign value_ext   = {1'b0, req_value};
   assign modulus_ext = {1'b0, req_modulus};
   assign value_w     = value_ext[WORD_BITS-1:0];
   assign modulus_w   = modulus_ext[WORD_BITS-1:0];

   assign accept   = start && (state_ff == ST_IDLE);
   assign div_last = (cnt_ff == CNT_LAST);
   assign rem_zero = (rem_new_ff == '0);

   assign trial_shift = {part_ff, quo_ff[WORD_BITS-1]};
   assign trial_diff  = trial_shift - {1'b0, rem_new_ff};
   assign quo_bit     = ~trial_diff[WORD_BITS];
   assign part_next   = quo_bit ? trial_diff[WORD_BITS-1:0] : trial_shift[WORD_BITS-1:0];

   assign acc_sum = acc_a + acc_b + {{(WORD_BITS-1){1'b0}}, acc_cin};
   assign fix_ext = 64'(co_old_ff[WORD_BITS-1] ? acc_sum : co_old_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_CHECK;
         end
         ST_CHECK: begin
            state_in = rem_zero ? ST_FIX : ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (div_last) state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            state_in = ST_CHECK;
         end
         ST_FIX: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // adder operand selection and datapath next values
   always_comb begin
      acc_a          = co_old_ff;
      acc_b          = mod_ff;
      acc_cin        = 1'b0;
      rem_old_in     = rem_old_ff;
      rem_new_in     = rem_new_ff;
      co_old_in      = co_old_ff;
      co_new_in      = co_new_ff;
      mod_in         = mod_ff;
      prod_in        = prod_ff;
      part_in        = part_ff;
      quo_in         = quo_ff;
      cnt_in         = cnt_ff;
      rsp_valid_in   = 1'b0;
      rsp_inverse_in = rsp_inverse_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               rem_old_in = modulus_w;
               rem_new_in = value_w;
               co_old_in  = '0;
               co_new_in  = {{(WORD_BITS-1){1'b0}}, 1'b1};
               mod_in     = modulus_w;
            end
         end
         ST_CHECK: begin
            part_in = '0;
            quo_in  = rem_old_ff;
            prod_in = '0;
            cnt_in  = '0;
         end
         ST_DIVIDE: begin
            // quotient bits arrive msb first, so shift-and-add gives quo * co_new
            acc_a   = {prod_ff[WORD_BITS-2:0], 1'b0};
            acc_b   = quo_bit ? co_new_ff : '0;
            prod_in = acc_sum;
            part_in = part_next;
            quo_in  = {quo_ff[WORD_BITS-2:0], quo_bit};
            cnt_in  = cnt_ff + 1'b1;
         end
         ST_UPDATE: begin
            acc_a      = co_old_ff;
            acc_b      = ~prod_ff;
            acc_cin    = 1'b1;
            co_old_in  = co_new_ff;
            co_new_in  = acc_sum;
            rem_old_in = rem_new_ff;
            rem_new_in = part_ff;
         end
         ST_FIX: begin
            rsp_inverse_in = fix_ext[FIELD_BITS-1:0];
            rsp_valid_in   = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_old_ff     <= rem_old_in;
      rem_new_ff     <= rem_new_in;
      co_old_ff      <= co_old_in;
      co_new_ff      <= co_new_in;
      mod_ff         <= mod_in;
      prod_ff        <= prod_in;
      part_ff        <= part_in;
      quo_ff         <= quo_in;
      cnt_ff         <= cnt_in;
      rsp_inverse_ff <= rsp_inverse_in;
   end

   assign busy        = (state_ff != ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_inverse = rsp_inverse_ff;

   // divisor is never zero while dividing
   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIVIDE) |-> (rem_new_ff != '0))
      else $error("division started with a zero divisor");

   // the partial remainder stays below the divisor
   a_part_below: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UPDATE) |-> (part_ff < rem_new_ff))
      else $error("remainder not below divisor at update");

   // a result only follows the sign fix
   a_rsp_after_fix: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ($past(state_ff) == ST_FIX))
      else $error("result strobe without a sign fix");

   // an accepted transaction always goes to the zero check
   a_accept_check: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_CHECK))
      else $error("accepted transaction did not start");

endmodule

`default_nettype wire

// ===== verif/tb_modular_inverse_ext_euclid.sv =====
// self-checking testbench for the extended euclidean modular inverse block
`default_nettype none

module tb_modular_inverse_ext_euclid;
   import mie_pkg::*;

   localparam int unsigned WORD_BITS = 64;
   // longest item is about 92 euclid steps; the stall limit covers it several times over
   localparam int unsigned STALL_LIMIT = 40000;
   localparam int unsigned DRAIN_CYCLES = 20;
   localparam int unsigned RANDOM_ITEMS = 100;

   typedef logic [FIELD_BITS-1:0] field_type;
   typedef logic [WORD_BITS-1:0] word_type;

   typedef struct {
      field_type value;
      field_type modulus;
   } inverse_request_type;

   localparam field_type FIELD_MAX = {FIELD_BITS{1'b1}};

   logic      clock = 1'b0;
   logic      reset = 1'b1;
   logic      start = 1'b0;
   field_type req_value = '0;
   field_type req_modulus = '0;
   logic      busy;
   logic      rsp_valid;
   field_type rsp_inverse;

   inverse_request_type request_queue[$];
   field_type           expected_inverses[$];
   int unsigned         error_count = 0;
   int unsigned         gap_left = 0;
   bit                  burst_mode = 1'b0;
   bit                  took_request;
   int unsigned         stall_cycles = 0;

   modular_inverse_ext_euclid #(
      .WORD_BITS(WORD_BITS)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_value(req_value),
      .req_modulus(req_modulus),
      .rsp_valid(rsp_valid),
      .rsp_inverse(rsp_inverse)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // bezout coefficient of value with wrapping signed coefficients, fixed up once
   function automatic field_type bezout_inverse(input field_type value,
                                                input field_type modulus);
      word_type rem_prev, rem_cur, coef_prev, coef_cur, quot, tmp;
      rem_prev = word_type'(modulus);
      rem_cur = word_type'(value);
      coef_prev = '0;
      coef_cur = word_type'(1);
      while (rem_cur != '0) begin
         quot = rem_prev / rem_cur;
         tmp = coef_prev - quot * coef_cur;
         coef_prev = coef_cur;
         coef_cur = tmp;
         tmp = rem_prev - quot * rem_cur;
         rem_prev = rem_cur;
         rem_cur = tmp;
      end
      if (coef_prev[WORD_BITS-1])
         coef_prev = coef_prev + word_type'(modulus);
      return field_type'(coef_prev);
   endfunction

   function automatic field_type random_field();
      logic [63:0] w;
      w = {$urandom(), $urandom()};
      return w[FIELD_BITS-1:0];
   endfunction

   task automatic queue_request(input field_type value, input field_type modulus);
      inverse_request_type r;
      r.value = value;
      r.modulus = modulus;
      request_queue.push_back(r);
   endtask

   task automatic report_mismatch(input string what, input field_type got,
                                  input field_type want);
      $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $time);
      error_count++;
   endtask

   // one random transaction, mostly well-formed with a spread of shapes
   task automatic queue_random_request();
      field_type a, b, g;
      a = random_field();
      b = random_field();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: begin
            if (b == '0)
               b = field_type'(1);
         end
         4: begin
            a = field_type'($urandom_range(0, 255));
            b = field_type'($urandom_range(1, 255));
         end
         5: begin
            if (a < b) begin
               g = a;
               a = b;
               b = g;
            end
            if (b == '0)
               b = field_type'(1);
         end
         6: begin
            // shared factor, so not coprime
            g = field_type'($urandom_range(2, 50));
            a = field_type'($urandom()) * g;
            b = (field_type'($urandom()) + field_type'(1)) * g;
         end
         7: begin
            a = a >> $urandom_range(0, FIELD_BITS - 1);
            b = b >> $urandom_range(0, FIELD_BITS - 1);
            if (b == '0)
               b = field_type'(1);
         end
         8: begin
            case ($urandom_range(0, 2))
               0: a = '0;
               1: a = field_type'(1);
               default: b = field_type'(1);
            endcase
            if (b == '0)
               b = field_type'(1);
         end
         default: begin
            b = field_type'(1) << $urandom_range(1, FIELD_BITS - 1);
            if ($urandom_range(0, 1) == 1)
               b = b - field_type'(1);
            if (b == '0)
               b = field_type'(1);
         end
      endcase
      queue_request(a, b);
   endtask

   // driver: holds a transaction until taken, then waits its drawn gap
   always @(posedge clock) begin
      inverse_request_type next_req;
      if (reset) begin
         start <= 1'b0;
         gap_left <= 0;
      end else begin
         took_request = start && !busy;
         if (took_request)
            expected_inverses.push_back(bezout_inverse(req_value, req_modulus));
         if (start && !took_request) begin
            // keep presenting the same transaction
         end else if (gap_left != 0 || request_queue.size() == 0) begin
            start <= 1'b0;
            req_value <= random_field();
            req_modulus <= random_field();
            if (gap_left != 0)
               gap_left <= gap_left - 1;
         end else begin
            next_req = request_queue.pop_front();
            start <= 1'b1;
            req_value <= next_req.value;
            req_modulus <= next_req.modulus;
            if ($urandom_range(0, 7) == 0)
               burst_mode <= !burst_mode;
            gap_left <= burst_mode ? 0 : $urandom_range(0, 4);
         end
      end
   end

   // monitor: every strobe must match the oldest outstanding expectation
   always @(posedge clock) begin
      field_type want;
      if (!reset && rsp_valid) begin
         if (expected_inverses.size() == 0) begin
            report_mismatch("unexpected result", rsp_inverse, '0);
         end else begin
            want = expected_inverses.pop_front();
            if (rsp_inverse !== want)
               report_mismatch("inverse", rsp_inverse, want);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid)
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("modular_inverse_ext_euclid test failed");
         $finish;
      end
   end

   initial begin
      // directed corners
      queue_request('0, random_field() | field_type'(1));
      queue_request('0, field_type'(1));
      queue_request(field_type'(1), field_type'(1));
      queue_request(field_type'(5), field_type'(1));
      queue_request(field_type'(3), field_type'(7));
      queue_request(field_type'(1), field_type'(2));
      queue_request(FIELD_MAX, FIELD_MAX);
      queue_request(FIELD_MAX, FIELD_MAX - field_type'(1));
      queue_request(field_type'(1), FIELD_MAX);
      queue_request(FIELD_MAX - field_type'(1), FIELD_MAX);
      queue_request(field_type'(6), field_type'(9));
      queue_request(field_type'(10), field_type'(4));
      // zero modulus swaps the remainders on the first step
      queue_request(field_type'(7), '0);
      queue_request(FIELD_MAX, '0);
      queue_request('0, '0);
      // consecutive fibonacci numbers give the longest run of steps
      queue_request(field_type'(64'd4660046610375530309),
                    field_type'(64'd7540113804746346429));
      queue_request(field_type'(2), field_type'(64'd2305843009213693951));
      queue_request(field_type'(64'h5555_5555_5555_5555),
                    field_type'(64'h2AAA_AAAA_AAAA_AAAA));
      queue_request(field_type'(64'h2AAA_AAAA_AAAA_AAAB),
                    field_type'(64'h5555_5555_5555_5555));
      queue_request(field_type'(1) << (FIELD_BITS - 1), FIELD_MAX);
      for (int i = 0; i < RANDOM_ITEMS; i++)
         queue_random_request();

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // checked away from the active edge so the driver's updates have settled
      while (request_queue.size() != 0 || start || expected_inverses.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0)
         $display("modular_inverse_ext_euclid test passed");
      else
         $display("modular_inverse_ext_euclid test failed");
      $finish;
   end

endmodule

`default_nettype wire
